@@ rtl/mrb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrb_pkg
// Shared types, constants and table functions of the modal resonator bank.
// ----------------------------------------------------------------------------
package mrb_pkg;

	localparam int MODES_DEFAULT        = 16;
	localparam int TANH_ENTRIES_DEFAULT = 256;

	localparam int SAMPLE_W     = 24;
	localparam int COEF_W       = 24;
	localparam int MODE_INDEX_W = 4;
	localparam int MIX_W        = 28;
	localparam int COUNT_W      = 32;
	localparam int MODES_CFG_W  = 5;
	localparam int CFG_DATA_W   = 5;
	localparam int CFG_INDEX_W  = 1;
	localparam int PROD_W       = SAMPLE_W + COEF_W;
	localparam int ACC_W        = PROD_W + 3;
	localparam int Y_W          = ACC_W - 21;
	localparam int TANH_W       = 21;
	localparam int FRAC_W       = 20;
	localparam int ROUND_SHIFT  = 22;

	localparam int MODES_RESET = 16;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_LOAD   = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_MODES_IN_USE = 1'd0,
		CFG_SAT_ENABLE   = 1'd1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_ACC,
		ST_ROUND,
		ST_LIMIT,
		ST_APPLY,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD4,
		ACC_ADD
	} acc_op_t;

	typedef struct packed {
		logic    mul_en;
		acc_op_t acc_op;
	} mac_ctrl_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] z1;
		logic signed [SAMPLE_W-1:0] z2;
	} hist_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] gain;
		logic signed [COEF_W-1:0]   a1;
		logic signed [COEF_W-1:0]   a2;
	} coef_t;

	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r    = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// tanh(8*k/entries / 2) in Q.20, built from exp(-2x) by series and squaring
	function automatic logic [TANH_W-1:0] tanh_entry(input int unsigned k,
		input int unsigned entries);
		logic [63:0] one;
		logic [63:0] u;
		logic [63:0] v;
		logic [63:0] t2;
		logic [63:0] t3;
		logic [63:0] t4;
		logic [63:0] e;
		logic [63:0] q;
		one = 64'd1 << 30;
		u   = udiv64(64'(k) << 33, 64'(entries));
		v   = u >> 8;
		t2  = ((v * v) >> 30) >> 1;
		t3  = ((t2 * v) >> 30) / 64'd3;
		t4  = ((t3 * v) >> 30) >> 2;
		e   = one - v + t2 - t3 + t4;
		for (int i = 0; i < 8; i++) begin
			e = (e * e + (one >> 1)) >> 30;
		end
		if (e > one) begin
			e = one;
		end
		q = udiv64(((one - e) << 20) + ((one + e) >> 1), one + e);
		return TANH_W'(q);
	endfunction

endpackage
`default_nettype wire

@@ rtl/mrb_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrb_in_if
// Input channel: sample, mode load and history clear transactions.
// ----------------------------------------------------------------------------
interface mrb_in_if;
	import mrb_pkg::*;

	logic                        valid;
	logic                        ready;
	kind_t                       kind;
	logic signed [SAMPLE_W-1:0]  excitation;
	logic [MODE_INDEX_W-1:0]     mode_index;
	logic                        mode_active;
	logic signed [SAMPLE_W-1:0]  mode_gain;
	logic signed [COEF_W-1:0]    feedback_first;
	logic signed [COEF_W-1:0]    feedback_second;

	modport source (
		output valid, kind, excitation, mode_index, mode_active, mode_gain,
			feedback_first, feedback_second,
		input  ready
	);

	modport sink (
		input  valid, kind, excitation, mode_index, mode_active, mode_gain,
			feedback_first, feedback_second,
		output ready
	);
endinterface
`default_nettype wire

@@ rtl/mrb_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrb_out_if
// Result channel: mixed sample and running soft-limit count.
// ----------------------------------------------------------------------------
interface mrb_out_if;
	import mrb_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [MIX_W-1:0]  mixed_sample;
	logic [COUNT_W-1:0]       saturation_count;

	modport source (
		output valid, mixed_sample, saturation_count,
		input  ready
	);

	modport sink (
		input  valid, mixed_sample, saturation_count,
		output ready
	);
endinterface
`default_nettype wire

@@ rtl/mrb_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrb_mac
// Shared 24x24 signed multiplier with product register and accumulator.
// ----------------------------------------------------------------------------
module mrb_mac (
	input  wire                                  clk,
	input  mrb_pkg::mac_ctrl_t                   ctrl,
	input  wire logic signed [mrb_pkg::COEF_W-1:0]   op_a,
	input  wire logic signed [mrb_pkg::SAMPLE_W-1:0] op_b,
	output logic signed [mrb_pkg::ACC_W-1:0]     acc
);
	import mrb_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s1 <= op_a * op_b;
		end
		case (ctrl.acc_op)
			ACC_LOAD4: acc_q <= ACC_W'(prod_s1) <<< 2;
			ACC_ADD:   acc_q <= acc_q + ACC_W'(prod_s1);
			default:   acc_q <= acc_q;
		endcase
	end

	assign acc = acc_q;
endmodule
`default_nettype wire

@@ rtl/modal_resonator_bank.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modal_resonator_bank
// Bank of two-pole resonators sharing one excitation stream, soft-limited
// through a tanh table and mixed into one saturated output sample.
//
// item: sample, load or clear transactions; ready is high only while idle.
// A load writes one mode's gain, a1, a2 and active flag; a clear drops all
// histories. Both finish in the cycle they are accepted and give no result.
// A sample scans min(modes_in_use, MODES) modes through one shared multiplier:
// an active mode steps through read, three multiply steps, accumulate, round,
// limit and apply; an inactive mode only through read. That multiplier and its
// accumulate sequence set the rate. The result then sits in an output
// register on result; the next transaction is taken while it waits.
// A stalled result holds the sequencer in its final step until the register
// frees. Reset clears config to 16 modes with limiting on, all active flags,
// histories and the soft-limit count; no clearing pass is needed.
// cfg: write cfg_data to register cfg_index when cfg_we is high, while idle.
// ----------------------------------------------------------------------------
module modal_resonator_bank #(
	parameter int MODES        = mrb_pkg::MODES_DEFAULT,
	parameter int TANH_ENTRIES = mrb_pkg::TANH_ENTRIES_DEFAULT
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	mrb_in_if.sink                               item,
	mrb_out_if.source                            result,
	input  wire                                  cfg_we,
	input  wire logic [mrb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [mrb_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mrb_pkg::*;

	localparam int IW      = (MODES > 1) ? $clog2(MODES) : 1;
	localparam int CW      = $clog2(MODES + 1);
	localparam int TAB_IW  = (TANH_ENTRIES > 1) ? $clog2(TANH_ENTRIES) : 1;
	localparam int SC_W    = Y_W + TAB_IW + 1;
	localparam int TI_W    = SC_W - ROUND_SHIFT;
	localparam int SUM_RAW = SAMPLE_W + $clog2(MODES) + 1;
	localparam int SUM_W   = (SUM_RAW > MIX_W) ? SUM_RAW : MIX_W;

	localparam logic signed [Y_W-1:0]   Y_TWO  = Y_W'(2 << FRAC_W);
	localparam logic signed [Y_W-1:0]   Y_NTWO = -Y_TWO;
	localparam logic signed [Y_W-1:0]   Y_HI   = Y_W'((1 << (SAMPLE_W - 1)) - 1);
	localparam logic signed [Y_W-1:0]   Y_LO   = -Y_HI - Y_W'(1);
	localparam logic signed [SUM_W-1:0] MIX_HI = SUM_W'((1 << (MIX_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] MIX_LO = -MIX_HI - SUM_W'(1);
	localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1 << (ROUND_SHIFT - 1));
	localparam logic [TANH_W-1:0]       T_ONE  = TANH_W'(1 << FRAC_W);
	localparam logic [SAMPLE_W-1:0]     LIM_BASE = SAMPLE_W'(2 << FRAC_W);

	logic [TANH_W-1:0] tanh_rom [TANH_ENTRIES];

	for (genvar k = 0; k < TANH_ENTRIES; k++) begin : g_tanh
		localparam logic [TANH_W-1:0] ENTRY = tanh_entry(k, TANH_ENTRIES);
		assign tanh_rom[k] = ENTRY;
	end

	state_t state_q;
	state_t state_d;

	logic [MODES_CFG_W-1:0]     cfg_modes_q;
	logic                       cfg_sat_q;
	logic [MODES-1:0]           active_q;
	logic [MODES-1:0]           hv_q;
	logic [CW-1:0]              ix_q;
	logic [CW-1:0]              n_q;
	logic [CW-1:0]              n_cap;
	logic [COUNT_W-1:0]         sat_count_q;
	logic                       out_valid_q;
	logic signed [MIX_W-1:0]    mix_q;
	logic [COUNT_W-1:0]         count_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [Y_W-1:0]      y_q;
	logic                       sat_q;
	logic [TANH_W-1:0]          t_q;

	hist_t hist_mem_q [MODES];
	coef_t coef_mem_q [MODES];
	hist_t hist_rd_q;
	coef_t coef_rd_q;

	logic       in_fire;
	logic       load_we;
	logic       mode_ok;
	logic       rd_en;
	logic       out_load;
	logic       cur_active;
	logic [IW-1:0] ix;
	mac_ctrl_t  mac_ctrl;

	logic signed [COEF_W-1:0]   op_a;
	logic signed [SAMPLE_W-1:0] op_b;
	logic signed [ACC_W-1:0]    acc;
	logic signed [ACC_W-1:0]    acc_rnd;
	logic signed [SAMPLE_W-1:0] z1_eff;
	logic signed [SAMPLE_W-1:0] z2_eff;

	logic [Y_W-1:0]        mag;
	logic [Y_W-1:0]        excess;
	logic [SC_W-1:0]       scaled;
	logic [TI_W-1:0]       ti;
	logic                  over;
	logic                  in_rng;
	logic signed [SAMPLE_W-1:0] lim;
	logic signed [SAMPLE_W-1:0] y_fin;
	logic signed [SUM_W-1:0]    mix_sat;

	assign ix         = ix_q[IW-1:0];
	assign cur_active = active_q[ix];
	assign in_fire    = item.valid && item.ready;
	assign mode_ok    = 32'(item.mode_index) < MODES;
	assign load_we    = in_fire && (item.kind == KIND_LOAD) && mode_ok;
	assign n_cap      = (32'(cfg_modes_q) > MODES) ? CW'(MODES) : CW'(cfg_modes_q);
	assign z1_eff     = hv_q[ix] ? hist_rd_q.z1 : '0;
	assign z2_eff     = hv_q[ix] ? hist_rd_q.z2 : '0;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && item.kind == KIND_SAMPLE) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (ix_q == n_q) begin
					state_d = ST_DONE;
				end else if (cur_active) begin
					state_d = ST_MUL0;
				end
			end
			ST_MUL0:  state_d = ST_MUL1;
			ST_MUL1:  state_d = ST_MUL2;
			ST_MUL2:  state_d = ST_ACC;
			ST_ACC:   state_d = ST_ROUND;
			ST_ROUND: state_d = ST_LIMIT;
			ST_LIMIT: state_d = ST_APPLY;
			ST_APPLY: state_d = ST_READ;
			ST_DONE: begin
				if (!out_valid_q || result.ready) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item.ready      = 1'b0;
		rd_en           = 1'b0;
		out_load        = 1'b0;
		mac_ctrl.mul_en = 1'b0;
		mac_ctrl.acc_op = ACC_HOLD;
		unique case (state_q)
			ST_IDLE: item.ready = 1'b1;
			ST_READ: rd_en = (ix_q != n_q) && cur_active;
			ST_MUL0: mac_ctrl.mul_en = 1'b1;
			ST_MUL1: begin
				mac_ctrl.mul_en = 1'b1;
				mac_ctrl.acc_op = ACC_LOAD4;
			end
			ST_MUL2: begin
				mac_ctrl.mul_en = 1'b1;
				mac_ctrl.acc_op = ACC_ADD;
			end
			ST_ACC:  mac_ctrl.acc_op = ACC_ADD;
			ST_DONE: out_load = !out_valid_q || result.ready;
			default: ;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_MUL1: begin
				op_a = coef_rd_q.a1;
				op_b = z1_eff;
			end
			ST_MUL2: begin
				op_a = coef_rd_q.a2;
				op_b = z2_eff;
			end
			default: begin
				op_a = coef_rd_q.gain;
				op_b = x_q;
			end
		endcase
	end

	mrb_mac u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.op_a (op_a),
		.op_b (op_b),
		.acc  (acc)
	);

	assign acc_rnd = (acc + ACC_HALF) >>> ROUND_SHIFT;

	assign mag    = y_q[Y_W-1] ? Y_W'(-y_q) : Y_W'(y_q);
	assign over   = (y_q > Y_TWO) || (y_q < Y_NTWO);
	assign excess = mag - Y_W'(Y_TWO);
	assign scaled = SC_W'(excess) * SC_W'(TANH_ENTRIES);
	assign ti     = scaled[SC_W-1:ROUND_SHIFT];
	assign in_rng = ti < TI_W'(TANH_ENTRIES);

	assign lim = SAMPLE_W'(LIM_BASE + SAMPLE_W'(t_q >> 1));

	always_comb begin
		if (sat_q) begin
			y_fin = y_q[Y_W-1] ? -lim : lim;
		end else if (y_q > Y_HI) begin
			y_fin = SAMPLE_W'(Y_HI);
		end else if (y_q < Y_LO) begin
			y_fin = SAMPLE_W'(Y_LO);
		end else begin
			y_fin = SAMPLE_W'(y_q);
		end
	end

	always_comb begin
		if (sum_q > MIX_HI) begin
			mix_sat = MIX_HI;
		end else if (sum_q < MIX_LO) begin
			mix_sat = MIX_LO;
		end else begin
			mix_sat = sum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_modes_q <= MODES_CFG_W'(MODES_RESET);
			cfg_sat_q   <= 1'b1;
			active_q    <= '0;
			hv_q        <= '0;
			ix_q        <= '0;
			n_q         <= '0;
			sat_count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_MODES_IN_USE: cfg_modes_q <= cfg_data[MODES_CFG_W-1:0];
					CFG_SAT_ENABLE:   cfg_sat_q   <= cfg_data[0];
					default: ;
				endcase
			end
			if (load_we) begin
				active_q[IW'(item.mode_index)] <= item.mode_active;
			end
			if (in_fire && item.kind == KIND_CLEAR) begin
				hv_q <= '0;
			end else if (state_q == ST_APPLY) begin
				hv_q[ix] <= 1'b1;
			end
			if (in_fire && item.kind == KIND_SAMPLE) begin
				ix_q <= '0;
				n_q  <= n_cap;
			end else if ((state_q == ST_READ && ix_q != n_q && !cur_active)
					|| state_q == ST_APPLY) begin
				ix_q <= ix_q + CW'(1);
			end
			if (state_q == ST_APPLY && sat_q) begin
				sat_count_q <= sat_count_q + COUNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && item.kind == KIND_SAMPLE) begin
			x_q   <= item.excitation;
			sum_q <= '0;
		end else if (state_q == ST_APPLY) begin
			sum_q <= sum_q + SUM_W'(y_fin);
		end
		if (state_q == ST_ROUND) begin
			y_q <= Y_W'(acc_rnd);
		end
		if (state_q == ST_LIMIT) begin
			sat_q <= cfg_sat_q && over;
			t_q   <= in_rng ? tanh_rom[ti[TAB_IW-1:0]] : T_ONE;
		end
		if (out_load) begin
			mix_q   <= MIX_W'(mix_sat);
			count_q <= sat_count_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load_we) begin
			coef_mem_q[IW'(item.mode_index)] <= '{gain: item.mode_gain,
				a1: item.feedback_first, a2: item.feedback_second};
		end
		if (state_q == ST_APPLY) begin
			hist_mem_q[ix] <= '{z1: y_fin, z2: z1_eff};
		end
		if (rd_en) begin
			coef_rd_q <= coef_mem_q[ix];
			hist_rd_q <= hist_mem_q[ix];
		end
	end

	assign result.valid            = out_valid_q;
	assign result.mixed_sample     = mix_q;
	assign result.saturation_count = count_q;
endmodule
`default_nettype wire
